// ===== rtl/core/rprs_pkg.sv =====
// Package for the real-time / priority / round-robin scheduler.
// Holds opcodes, status and class codes, FSM state type and command structs.
// No dependencies.
package rprs_pkg;

    localparam int RtSlots   = 16;
    localparam int PrioSlots = 16;
    localparam int RrSlots   = 16;
    localparam int CycleLen  = 60;
    localparam int SlotW     = 4;
    localparam int CntW      = 5;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ADD_RT   = 3'd1;
    localparam logic [2:0] OP_ADD_PRIO = 3'd2;
    localparam logic [2:0] OP_ADD_RR   = 3'd3;
    localparam logic [2:0] OP_FINISH   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_PAST_END = 2'd2;
    localparam logic [1:0] ST_CONFLICT = 2'd3;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_RT   = 2'd1;
    localparam logic [1:0] CLS_PRIO = 2'd2;
    localparam logic [1:0] CLS_RR   = 2'd3;

    localparam logic [3:0] NO_PRIO = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_END_SCAN,
        S_START_SCAN,
        S_PRIO_SCAN,
        S_RR,
        S_CONF_SCAN,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;      // capture input item, clear scan index
        logic             end_step;  // check window end at scan index
        logic             start_step;// check window start at scan index
        logic             prio_step; // compare priority at scan index
        logic             conf_step; // overlap test at scan index
        logic             rr_do;     // round-robin service
        logic             prio_pick; // commit priority winner
        logic             add_do;    // simple add / finish / commit realtime add
        logic             clr_idx;   // restart scan index
        logic             finish;    // write result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       rt_last;   // scan index at last realtime entry
        logic       rt_empty;
        logic       prio_last;
        logic       prio_empty;
        logic       rt_on;
        logic       prio_found;
        logic       rt_reject; // full, zero length or past end
        logic       conflict;
    } stat_t;

endpackage

// ===== rtl/core/rprs_if.sv =====
// Valid/ready channel interfaces for the scheduler.
// Depends on nothing; payload fields follow the item formats.
interface rprs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [5:0] current_second;
    logic [5:0] window_start;
    logic [5:0] window_length;
    logic [2:0] prio_level;
    logic [3:0] target_slot;
    modport source (output valid, opcode, current_second, window_start, window_length,
                    prio_level, target_slot, input ready);
    modport sink (input valid, opcode, current_second, window_start, window_length,
                  prio_level, target_slot, output ready);
endinterface

interface rprs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] assigned_slot;
    logic [1:0] run_class;
    logic [3:0] run_slot;
    logic       window_busy;
    logic       all_prio_done;
    modport source (output valid, status, assigned_slot, run_class, run_slot,
                    window_busy, all_prio_done, input ready);
    modport sink (input valid, status, assigned_slot, run_class, run_slot,
                  window_busy, all_prio_done, output ready);
endinterface

// ===== rtl/core/rprs_ctrl.sv =====
// Controller FSM of the scheduler: sequences scans one entry per cycle.
// Depends on rprs_pkg.
module rprs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            res_free,
    input  rprs_pkg::stat_t st,
    output rprs_pkg::cmd_t  cmd
);
    import rprs_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && res_free)
                begin
                    state_next = S_FINISH;
                    if (st.op == OP_TICK) state_next = S_END_SCAN;
                    if (st.op == OP_ADD_RT) state_next = S_CONF_SCAN;
                end
            end
            S_END_SCAN:
                if (st.rt_empty || st.rt_last) state_next = S_START_SCAN;
            S_START_SCAN:
            begin
                if (st.rt_empty || st.rt_last)
                begin
                    state_next = S_PRIO_SCAN;
                end
            end
            S_PRIO_SCAN:
            begin
                if (st.rt_on) state_next = S_FINISH;
                else if (st.prio_empty || st.prio_last) state_next = S_RR;
            end
            S_RR:
                state_next = S_FINISH;
            S_CONF_SCAN:
            begin
                if (st.rt_reject || st.conflict || st.rt_empty || st.rt_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = res_free;
                cmd.load = in_valid && res_free;
            end
            S_END_SCAN:
            begin
                cmd.end_step = !st.rt_empty;
                if (st.rt_empty || st.rt_last) cmd.clr_idx = 1'b1;
            end
            S_START_SCAN:
            begin
                cmd.start_step = !st.rt_empty;
                if (st.rt_empty || st.rt_last) cmd.clr_idx = 1'b1;
            end
            S_PRIO_SCAN:
            begin
                cmd.prio_step = !st.rt_on && !st.prio_empty;
            end
            S_RR:
            begin
                if (st.prio_found) cmd.prio_pick = 1'b1;
                else cmd.rr_do = 1'b1;
            end
            S_CONF_SCAN:
            begin
                cmd.conf_step = !st.rt_reject && !st.rt_empty;
            end
            S_FINISH:
            begin
                cmd.add_do = 1'b1;
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/rprs_dp.sv =====
// Datapath of the scheduler: entry tables, counters, scan index, result fields.
// Depends on rprs_pkg; driven by rprs_ctrl commands.
module rprs_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  rprs_pkg::cmd_t  cmd,
    output rprs_pkg::stat_t st,
    input  logic [2:0]      in_opcode,
    input  logic [5:0]      in_second,
    input  logic [5:0]      in_wstart,
    input  logic [5:0]      in_wlen,
    input  logic [2:0]      in_level,
    input  logic [3:0]      in_target,
    input  logic [3:0]      slice_ticks,
    output logic [1:0]      res_status,
    output logic [3:0]      res_assigned,
    output logic [1:0]      res_class,
    output logic [3:0]      res_slot,
    output logic            res_busy,
    output logic            res_alldone
);
    import rprs_pkg::*;

    logic [5:0]     rt_begin_reg   [RtSlots];
    logic [5:0]     rt_finish_reg  [RtSlots];
    logic [2:0]     prio_value_reg [PrioSlots];
    logic [3:0]     rr_rem_reg     [RrSlots];
    logic [PrioSlots-1:0] prio_done_reg;
    logic [CntW-1:0] rt_cnt_reg, prio_cnt_reg, done_cnt_reg, rr_cnt_reg;
    logic           rt_on_reg;
    logic [SlotW-1:0] rt_cur_reg, rr_ptr_reg;

    logic [2:0]     op_reg, level_reg;
    logic [5:0]     sec_reg, wstart_reg;
    logic [6:0]     wfin_reg;
    logic [SlotW-1:0] target_reg, idx_reg;
    logic [3:0]     best_reg;
    logic [SlotW-1:0] best_idx_reg;
    logic           found_reg, conflict_reg;
    logic [1:0]     cls_reg;
    logic [SlotW-1:0] rslot_reg;

    logic [5:0] cur_begin, cur_finish;
    logic [2:0] cur_prio;
    logic [SlotW-1:0] ptr_next;

    assign cur_begin  = rt_begin_reg[idx_reg];
    assign cur_finish = rt_finish_reg[idx_reg];
    assign cur_prio   = prio_value_reg[idx_reg];
    assign ptr_next   = (CntW'(rr_ptr_reg) + 1'b1 >= rr_cnt_reg) ? '0 : rr_ptr_reg + 1'b1;

    // Status toward the controller.
    always_comb
    begin
        st.op         = cmd.load ? in_opcode : op_reg;
        st.rt_empty   = (rt_cnt_reg == '0);
        st.rt_last    = (CntW'(idx_reg) + 1'b1 == rt_cnt_reg);
        st.prio_empty = (prio_cnt_reg == '0);
        st.prio_last  = (CntW'(idx_reg) + 1'b1 == prio_cnt_reg);
        st.rt_on      = rt_on_reg;
        st.prio_found = found_reg;
        st.rt_reject  = (rt_cnt_reg >= CntW'(RtSlots)) || (wfin_reg == wstart_reg)
                        || (wfin_reg > 7'(CycleLen));
        st.conflict   = conflict_reg;
    end

    // Captured item and scan registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_opcode;
            sec_reg    <= in_second;
            wstart_reg <= in_wstart;
            wfin_reg   <= 7'(in_wstart) + 7'(in_wlen);
            level_reg  <= in_level;
            target_reg <= in_target;
            idx_reg    <= '0;
            best_reg   <= NO_PRIO;
            best_idx_reg <= '0;
            found_reg  <= 1'b0;
            conflict_reg <= 1'b0;
            cls_reg    <= CLS_NONE;
            rslot_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_idx) idx_reg <= '0;
            else if (cmd.end_step || cmd.start_step || cmd.prio_step || cmd.conf_step)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.prio_step && !prio_done_reg[idx_reg] && {1'b0, cur_prio} < best_reg)
            begin
                best_reg <= {1'b0, cur_prio};
                best_idx_reg <= idx_reg;
                found_reg <= 1'b1;
            end
            if (cmd.conf_step && 7'(wstart_reg) < 7'(cur_finish) && 7'(cur_begin) < wfin_reg)
                conflict_reg <= 1'b1;
            if (cmd.prio_pick)
            begin
                cls_reg <= CLS_PRIO;
                rslot_reg <= best_idx_reg;
            end
            if (cmd.rr_do && rr_cnt_reg != '0 && rr_rem_reg[rr_ptr_reg] != '0)
            begin
                cls_reg <= CLS_RR;
                rslot_reg <= rr_ptr_reg;
            end
        end
    end

    // Entry tables; contents need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.add_do && op_reg == OP_ADD_RT && !st.rt_reject && !conflict_reg)
        begin
            rt_begin_reg[rt_cnt_reg[SlotW-1:0]]  <= wstart_reg;
            rt_finish_reg[rt_cnt_reg[SlotW-1:0]] <= wfin_reg[5:0];
        end
        if (cmd.add_do && op_reg == OP_ADD_PRIO && prio_cnt_reg < CntW'(PrioSlots))
            prio_value_reg[prio_cnt_reg[SlotW-1:0]] <= level_reg;
        if (cmd.add_do && op_reg == OP_ADD_RR && rr_cnt_reg < CntW'(RrSlots))
            rr_rem_reg[rr_cnt_reg[SlotW-1:0]] <= slice_ticks;
        if (cmd.rr_do && rr_cnt_reg != '0)
        begin
            if (rr_rem_reg[rr_ptr_reg] > 4'd1)
                rr_rem_reg[rr_ptr_reg] <= rr_rem_reg[rr_ptr_reg] - 1'b1;
            else
                rr_rem_reg[ptr_next] <= slice_ticks;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_cnt_reg    <= '0;
            prio_cnt_reg  <= '0;
            done_cnt_reg  <= '0;
            rr_cnt_reg    <= '0;
            rt_on_reg     <= 1'b0;
            rt_cur_reg    <= '0;
            rr_ptr_reg    <= '0;
            prio_done_reg <= '0;
        end
        else
        begin
            if (cmd.end_step && (cur_finish == sec_reg ||
                (cur_finish == 6'(CycleLen) && sec_reg == '0)))
                rt_on_reg <= 1'b0;
            if (cmd.start_step && cur_begin == sec_reg)
            begin
                rt_on_reg  <= 1'b1;
                rt_cur_reg <= idx_reg;
            end
            if (cmd.rr_do && rr_cnt_reg != '0 && rr_rem_reg[rr_ptr_reg] <= 4'd1)
                rr_ptr_reg <= ptr_next;
            if (cmd.add_do)
            begin
                unique case (op_reg)
                    OP_ADD_RT:
                        if (!st.rt_reject && !conflict_reg) rt_cnt_reg <= rt_cnt_reg + 1'b1;
                    OP_ADD_PRIO:
                    begin
                        if (prio_cnt_reg < CntW'(PrioSlots))
                        begin
                            prio_done_reg[prio_cnt_reg[SlotW-1:0]] <= 1'b0;
                            prio_cnt_reg <= prio_cnt_reg + 1'b1;
                        end
                    end
                    OP_ADD_RR:
                        if (rr_cnt_reg < CntW'(RrSlots)) rr_cnt_reg <= rr_cnt_reg + 1'b1;
                    OP_FINISH:
                    begin
                        if (CntW'(target_reg) < prio_cnt_reg && !prio_done_reg[target_reg])
                        begin
                            prio_done_reg[target_reg] <= 1'b1;
                            done_cnt_reg <= done_cnt_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result fields, valid in the finish state.
    always_comb
    begin
        res_status   = ST_OK;
        res_assigned = '0;
        res_class    = CLS_NONE;
        res_slot     = '0;
        unique case (op_reg)
            OP_TICK:
            begin
                if (rt_on_reg)
                begin
                    res_class = CLS_RT;
                    res_slot  = rt_cur_reg;
                end
                else
                begin
                    res_class = cls_reg;
                    res_slot  = rslot_reg;
                end
            end
            OP_ADD_RT:
            begin
                if (rt_cnt_reg >= CntW'(RtSlots)) res_status = ST_FULL;
                else if (st.rt_reject) res_status = ST_PAST_END;
                else if (conflict_reg) res_status = ST_CONFLICT;
                else res_assigned = rt_cnt_reg[SlotW-1:0];
            end
            OP_ADD_PRIO:
            begin
                if (prio_cnt_reg >= CntW'(PrioSlots)) res_status = ST_FULL;
                else res_assigned = prio_cnt_reg[SlotW-1:0];
            end
            OP_ADD_RR:
            begin
                if (rr_cnt_reg >= CntW'(RrSlots)) res_status = ST_FULL;
                else res_assigned = rr_cnt_reg[SlotW-1:0];
            end
            default:
            begin
            end
        endcase
        res_busy = rt_on_reg;
        res_alldone = 1'b0;
        unique case (op_reg)
            OP_ADD_PRIO:
                res_alldone = (prio_cnt_reg >= CntW'(PrioSlots)) &&
                              (done_cnt_reg == prio_cnt_reg);
            OP_FINISH:
                res_alldone = (CntW'(target_reg) < prio_cnt_reg && !prio_done_reg[target_reg])
                              ? (done_cnt_reg + 1'b1 == prio_cnt_reg)
                              : (done_cnt_reg == prio_cnt_reg);
            default:
                res_alldone = (done_cnt_reg == prio_cnt_reg);
        endcase
    end

endmodule

// ===== rtl/core/realtime_priority_roundrobin_scheduler.sv =====
// Top level of the three-level scheduler (real-time windows, priority, round-robin).
// Depends on rprs_pkg, rprs_if, rprs_ctrl and rprs_dp.
//
// Usage: items enter on the "inp" valid/ready channel, one result item per input
// leaves on the "outp" channel. slice_ticks is written through cfg_we/cfg_wdata;
// write it only while the block is idle, which the block itself does not enforce.
// One input item is handled at a time. An add or finish goes straight from idle
// to the finish state; a realtime add first runs the overlap scan over the entries.
// A tick scans the window ends, then the window starts, then the priority values
// (skipped while a window is active), one entry per cycle each, then commits the
// priority winner or serves round-robin.
// The result sits in an output register. A new item is taken only when that
// register is empty or is read in the same cycle, so a stalled receiver stops
// the input while one result waits.
// Reset empties every table count, clears the active window and the round-robin
// pointer, and sets slice_ticks to 3; no clearing pass is needed.
module realtime_priority_roundrobin_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    rprs_in_if.sink    inp,
    rprs_out_if.source outp
);
    import rprs_pkg::*;

    cmd_t       cmd;
    stat_t      st;
    logic [3:0] slice_reg;
    logic [1:0] r_status, r_class;
    logic [3:0] r_assigned, r_slot;
    logic       r_busy, r_alldone;
    logic       out_valid_reg;
    logic       res_free;

    assign res_free = !out_valid_reg || outp.ready;

    // Slice length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) slice_reg <= 4'd3;
        else if (cfg_we) slice_reg <= cfg_wdata;
    end

    rprs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (inp.valid),
        .in_ready (inp.ready),
        .res_free (res_free),
        .st       (st),
        .cmd      (cmd)
    );

    rprs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_opcode    (inp.opcode),
        .in_second    (inp.current_second),
        .in_wstart    (inp.window_start),
        .in_wlen      (inp.window_length),
        .in_level     (inp.prio_level),
        .in_target    (inp.target_slot),
        .slice_ticks  (slice_reg),
        .res_status   (r_status),
        .res_assigned (r_assigned),
        .res_class    (r_class),
        .res_slot     (r_slot),
        .res_busy     (r_busy),
        .res_alldone  (r_alldone)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (cmd.finish) out_valid_reg <= 1'b1;
        else if (outp.ready) out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            outp.status        <= r_status;
            outp.assigned_slot <= r_assigned;
            outp.run_class     <= r_class;
            outp.run_slot      <= r_slot;
            outp.window_busy   <= r_busy;
            outp.all_prio_done <= r_alldone;
        end
    end

    assign outp.valid = out_valid_reg;

endmodule
